// ----- sv/asp_pkg.sv -----
`default_nettype none

package asp_pkg;

    localparam int EDGE_W  = 18;   // signed box edges and differences
    localparam int DIST_W  = 17;   // unsigned edge distances
    localparam int VEL_W   = 16;   // |velocity| in Q8.8
    localparam int PROD_W  = DIST_W + VEL_W;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = PROD_W + FRAC_W;
    localparam int Q_W     = 25;   // quotient bits, also push width
    localparam int PUSH_W  = 25;
    localparam int REM_W   = VEL_W + 1;
    localparam int DIV_STAGES = Q_W;

    localparam int IN_W  = 160;
    localparam int OUT_W = 56;

    typedef struct packed {
        logic                hit;
        logic                diag;
        logic                xwin;
        logic                negx;
        logic                negy;
        logic [DIST_W-1:0]   dx;
        logic [DIST_W-1:0]   dy;
        logic [PUSH_W-1:0]   pxn;
        logic [PUSH_W-1:0]   pyn;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [VEL_W-1:0]   ax;
        logic [VEL_W-1:0]   ay;
    } geom_t;

    typedef struct packed {
        side_t              side;
        logic [REM_W-1:0]   rem;
        logic [Q_W-1:0]     n;
        logic [Q_W-1:0]     q;
        logic [VEL_W-1:0]   den;
    } div_t;

endpackage

`default_nettype wire

// ----- sv/asp_front.sv -----
`default_nettype none

module asp_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [asp_pkg::IN_W-1:0]  in_data,
    output logic                           out_valid,
    output asp_pkg::div_t                  out_div
);
    import asp_pkg::*;

    logic signed [EDGE_W-1:0] fx, fy, fw, fh, sx, sy, sw, sh;
    logic signed [EDGE_W-1:0] fr, fb, sr, sb, iw, ih, tx, ty;
    logic signed [EDGE_W:0]   dcx, dcy;
    logic signed [VEL_W-1:0]  vx, vy;
    geom_t                    g1_next;
    logic                     hit;

    geom_t               g1_reg, g2_reg;
    logic                v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]   p1_reg, p2_reg;
    div_t                d3_reg;
    div_t                d3_next;
    logic                xwin;

    always_comb
    begin
        fx = EDGE_W'(signed'(in_data[15:0]));
        fy = EDGE_W'(signed'(in_data[31:16]));
        fw = EDGE_W'({1'b0, in_data[46:32]});
        fh = EDGE_W'({1'b0, in_data[61:47]});
        sx = EDGE_W'(signed'(in_data[77:62]));
        sy = EDGE_W'(signed'(in_data[93:78]));
        sw = EDGE_W'({1'b0, in_data[108:94]});
        sh = EDGE_W'({1'b0, in_data[123:109]});
        vx = signed'(in_data[139:124]);
        vy = signed'(in_data[155:140]);

        fr = fx + fw;
        fb = fy + fh;
        sr = sx + sw;
        sb = sy + sh;
        hit = (fw != '0) && (fh != '0) && (sw != '0) && (sh != '0) &&
              (fx < sr) && (sx < fr) && (fy < sb) && (sy < fb);

        iw = ((fr < sr) ? fr : sr) - ((fx > sx) ? fx : sx);
        ih = ((fb < sb) ? fb : sb) - ((fy > sy) ? fy : sy);
        dcx = ((EDGE_W+1)'(sx) <<< 1) + (EDGE_W+1)'(sw)
            - ((EDGE_W+1)'(fx) <<< 1) - (EDGE_W+1)'(fw);
        dcy = ((EDGE_W+1)'(sy) <<< 1) + (EDGE_W+1)'(sh)
            - ((EDGE_W+1)'(fy) <<< 1) - (EDGE_W+1)'(fh);

        tx = '0;
        ty = '0;
        if (vx == '0 && vy == '0)
        begin
            if (iw > ih)
                ty = (dcy > 0) ? -ih : ih;
            else
                tx = (dcx > 0) ? -iw : iw;
        end
        else if (vx == '0)
            ty = (vy > 0) ? (sb - fy) : -(fb - sy);
        else if (vy == '0)
            tx = (vx > 0) ? (sr - fx) : -(fr - sx);

        g1_next.side.hit  = hit;
        g1_next.side.diag = (vx != '0) && (vy != '0);
        g1_next.side.xwin = 1'b0;
        g1_next.side.negx = vx < 0;
        g1_next.side.negy = vy < 0;
        g1_next.side.dx   = DIST_W'((vx > 0) ? (sr - fx) : (fr - sx));
        g1_next.side.dy   = DIST_W'((vy > 0) ? (sb - fy) : (fb - sy));
        g1_next.side.pxn  = {tx[PUSH_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        g1_next.side.pyn  = {ty[PUSH_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        g1_next.ax        = (vx < 0) ? VEL_W'(-vx) : VEL_W'(vx);
        g1_next.ay        = (vy < 0) ? VEL_W'(-vy) : VEL_W'(vy);
    end

    // stage 3: pick winning axis, set up quotient numerator
    always_comb
    begin
        xwin = p1_reg < p2_reg;   // ties go to y
        d3_next.side      = g2_reg.side;
        d3_next.side.xwin = xwin;
        if (xwin)
        begin
            d3_next.rem = REM_W'(p1_reg[PROD_W-1:PROD_W-VEL_W]);
            d3_next.n   = {p1_reg[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            d3_next.den = g2_reg.ax;
        end
        else
        begin
            d3_next.rem = REM_W'(p2_reg[PROD_W-1:PROD_W-VEL_W]);
            d3_next.n   = {p2_reg[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            d3_next.den = g2_reg.ay;
        end
        d3_next.q = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg <= g1_next;
            g2_reg <= g1_reg;
            p1_reg <= g1_reg.side.dx * g1_reg.ay;
            p2_reg <= g1_reg.side.dy * g1_reg.ax;
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_div   = d3_reg;

endmodule

`default_nettype wire

// ----- sv/asp_divider.sv -----
`default_nettype none

module asp_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  asp_pkg::div_t       in_div,
    output logic                out_valid,
    output asp_pkg::div_t       out_div
);
    import asp_pkg::*;

    div_t pipe_reg [1:DIV_STAGES];
    logic vld_reg  [1:DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : gen_stage
            div_t             cur;
            div_t             nxt;
            logic             cur_v;
            logic [REM_W-1:0] t;
            logic             ge;

            if (g == 0)
            begin : gen_first
                assign cur   = in_div;
                assign cur_v = in_valid;
            end
            else
            begin : gen_rest
                assign cur   = pipe_reg[g];
                assign cur_v = vld_reg[g];
            end

            always_comb
            begin
                t  = {cur.rem[REM_W-2:0], cur.n[Q_W-1]};
                ge = t >= REM_W'(cur.den);
                nxt      = cur;
                nxt.rem  = ge ? (t - REM_W'(cur.den)) : t;
                nxt.n    = {cur.n[Q_W-2:0], 1'b0};
                nxt.q    = {cur.q[Q_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= cur_v;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    pipe_reg[g+1] <= nxt;
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_STAGES];
    assign out_div   = pipe_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ----- sv/aabb_swept_pushout_core.sv -----
`default_nettype none
// Pipeline from input beat to output beat: 3 front stages, 25 restoring divider
//   stages at one quotient bit each, and 1 output register.
// Throughput: one beat per cycle; the whole pipe advances when the output
//   register is empty or being taken, and holds in place otherwise.
// Reset: rst_n asynchronous active low; clears all valid bits, data is not reset.

module aabb_swept_pushout_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // first_x, first_y, first_w, first_h, second_x, second_y,
    // second_w, second_h, push_dir_x, push_dir_y, 4 zero pad bits
    input  wire logic [asp_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // push_x, push_y, moved, 5 zero pad bits
    output logic [asp_pkg::OUT_W-1:0]      m_tdata
);
    import asp_pkg::*;

    logic  en;
    logic  f_valid, d_valid;
    div_t  f_div, d_div;

    logic                 out_valid_reg;
    logic [PUSH_W-1:0]    push_x_reg, push_y_reg;
    logic                 moved_reg;
    logic [PUSH_W-1:0]    push_x_next, push_y_next;
    logic [PUSH_W-1:0]    q_x, q_y, d_x, d_y;

    // pipe moves whenever the output register can take a new beat
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    asp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_div   (f_div)
    );

    asp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_div    (f_div),
        .out_valid (d_valid),
        .out_div   (d_div)
    );

    // final sign application and case select
    always_comb
    begin
        q_x = d_div.side.negx ? -d_div.q : d_div.q;
        q_y = d_div.side.negy ? -d_div.q : d_div.q;
        d_x = {d_div.side.dx, {FRAC_W{1'b0}}};
        d_y = {d_div.side.dy, {FRAC_W{1'b0}}};
        d_x = d_div.side.negx ? -d_x : d_x;
        d_y = d_div.side.negy ? -d_y : d_y;
        if (!d_div.side.hit)
        begin
            push_x_next = '0;
            push_y_next = '0;
        end
        else if (!d_div.side.diag)
        begin
            push_x_next = d_div.side.pxn;
            push_y_next = d_div.side.pyn;
        end
        else if (d_div.side.xwin)
        begin
            push_x_next = d_x;
            push_y_next = q_y;
        end
        else
        begin
            push_x_next = q_x;
            push_y_next = d_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            push_x_reg <= push_x_next;
            push_y_reg <= push_y_next;
            moved_reg  <= d_div.side.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, moved_reg, push_y_reg, push_x_reg};

`ifndef ASSERT_OFF
    // no hit means no push
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !moved_reg) |-> (push_x_reg == '0 && push_y_reg == '0))
        else $error("push without hit");

    // an accepted beat lands in the first front stage
    a_front_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> u_front.v1_reg)
        else $error("front stage lost beat");

    // a diagonal hit leaves a remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid && d_div.side.hit && d_div.side.diag)
            |-> (d_div.rem < REM_W'(d_div.den)))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/aabb_swept_pushout_core_tb.sv -----
`timescale 1ns / 100ps

module aabb_swept_pushout_core_tb;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [14:0]        fw;
        logic [14:0]        fh;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [14:0]        sw;
        logic [14:0]        sh;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } box_pair_t;

    typedef struct packed {
        logic [24:0] px;
        logic [24:0] py;
        logic        moved;
    } push_t;

    // Pushout calculation: 64-bit signed arithmetic, result masked to 25 bits
    function automatic push_t calc_push(box_pair_t b);
        longint fx, fy, fw, fh, sx, sy, sw, sh, vx, vy;
        longint fr, fb, sr, sb, px, py, iw, ih, dc, dx, dy, ax, ay, q;
        logic   hit;
        push_t  r;
        fx = b.fx; fy = b.fy; fw = b.fw; fh = b.fh;
        sx = b.sx; sy = b.sy; sw = b.sw; sh = b.sh;
        vx = b.vx; vy = b.vy;
        fr = fx + fw; fb = fy + fh; sr = sx + sw; sb = sy + sh;
        px = 0; py = 0;
        hit = fw != 0 && fh != 0 && sw != 0 && sh != 0 &&
              fx < sr && sx < fr && fy < sb && sy < fb;
        if (hit) begin
            if (vx == 0 && vy == 0) begin
                iw = (fr < sr ? fr : sr) - (fx > sx ? fx : sx);
                ih = (fb < sb ? fb : sb) - (fy > sy ? fy : sy);
                if (iw > ih) begin
                    dc = (2 * sy + sh) - (2 * fy + fh);
                    py = (dc > 0 ? -ih : ih) * 256;
                end
                else begin
                    dc = (2 * sx + sw) - (2 * fx + fw);
                    px = (dc > 0 ? -iw : iw) * 256;
                end
            end
            else if (vx == 0)
                py = (vy > 0 ? sb - fy : -(fb - sy)) * 256;
            else if (vy == 0)
                px = (vx > 0 ? sr - fx : -(fr - sx)) * 256;
            else begin
                dx = vx > 0 ? sr - fx : fr - sx;
                dy = vy > 0 ? sb - fy : fb - sy;
                ax = vx < 0 ? -vx : vx;
                ay = vy < 0 ? -vy : vy;
                if (dx * ay < dy * ax) begin
                    q  = (dx * 256 * ay) / ax;
                    px = (vx > 0 ? dx : -dx) * 256;
                    py = vy > 0 ? q : -q;
                end
                else begin
                    q  = (dy * 256 * ax) / ay;
                    px = vx > 0 ? q : -q;
                    py = (vy > 0 ? dy : -dy) * 256;
                end
            end
        end
        r.px = px[24:0];
        r.py = py[24:0];
        r.moved = hit;
        return r;
    endfunction

    int err_cnt;

    task automatic report_mismatch(string what, logic [24:0] got, logic [24:0] want);
        err_cnt++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    class push_scoreboard;
        push_t pending[$];
        int    n_in, n_out, n_hits;

        function void note_pair(box_pair_t b);
            pending.push_back(calc_push(b));
            n_in++;
        endfunction

        task check_push(push_t got);
            push_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", got.px, 0);
                return;
            end
            want = pending.pop_front();
            n_out++;
            if (got.moved) n_hits++;
            if (got.px !== want.px) report_mismatch("push_x", got.px, want.px);
            if (got.py !== want.py) report_mismatch("push_y", got.py, want.py);
            if (got.moved !== want.moved) report_mismatch("moved", got.moved, want.moved);
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;   // first_x, first_y, first_w, first_h, second_x, second_y,
                             // second_w, second_h, push_dir_x, push_dir_y, pad
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;   // push_x, push_y, moved, pad

    aabb_swept_pushout_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    push_scoreboard sb = new();
    int  send_idle_pct;      // chance per cycle that the sender holds off
    int  recv_stall_pct;     // chance per cycle that the receiver stalls
    bit  recv_hold;          // long receiver hold-off
    int  idle_cycles;

    // Pack fields low-first into tdata
    function automatic logic [159:0] pack_pair(box_pair_t b);
        logic [159:0] d;
        d = '0;
        d[15:0]    = b.fx;
        d[31:16]   = b.fy;
        d[46:32]   = b.fw;
        d[61:47]   = b.fh;
        d[77:62]   = b.sx;
        d[93:78]   = b.sy;
        d[108:94]  = b.sw;
        d[123:109] = b.sh;
        d[139:124] = b.vx;
        d[155:140] = b.vy;
        return d;
    endfunction

    box_pair_t sent_q[$];    // payload of the beat currently on the bus

    // One beat: optional idle cycles, then hold valid until accepted
    task automatic send_pair(box_pair_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(b);
        sent_q.push_back(b);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Input monitor
    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            sb.note_pair(sent_q.pop_front());

    // Output monitor; results are sampled at the edge before anything changes
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_push(push_t'{m_tdata[24:0], m_tdata[49:25], m_tdata[50]});

    // Receiver ready
    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("watchdog: no progress, %0d results outstanding", sb.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [15:0] rnd_pos();
        return $urandom_range(3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(80)) - 40);
    endfunction

    function automatic logic [14:0] rnd_size();
        case ($urandom_range(5))
            0: return 15'($urandom);
            1: return 15'($urandom_range(1));
            default: return 15'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_dir();
        case ($urandom_range(5))
            0: return 16'sd0;
            1: return 16'($urandom);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    // Random pair, mostly overlapping boxes so the push logic is exercised
    function automatic box_pair_t rnd_pair();
        box_pair_t b;
        b.fx = rnd_pos(); b.fy = rnd_pos();
        b.fw = rnd_size(); b.fh = rnd_size();
        b.sw = rnd_size(); b.sh = rnd_size();
        if ($urandom_range(9) < 8) begin
            b.sx = b.fx + 16'($signed($urandom_range(60)) - 30);
            b.sy = b.fy + 16'($signed($urandom_range(60)) - 30);
        end
        else begin
            b.sx = rnd_pos(); b.sy = rnd_pos();
        end
        b.vx = rnd_dir(); b.vy = rnd_dir();
        return b;
    endfunction

    function automatic box_pair_t mk(int fx, int fy, int fw, int fh, int sx, int sy,
                                     int sw, int sh, int vx, int vy);
        box_pair_t b;
        b = '{16'(fx), 16'(fy), 15'(fw), 15'(fh), 16'(sx), 16'(sy),
              15'(sw), 15'(sh), 16'(vx), 16'(vy)};
        return b;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    box_pair_t directed[$];
    int        phase;

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        recv_hold = 1'b0;
        idle_cycles = 0;
        err_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no hit, touching edges, zero sizes, overlap tie, centred boxes,
        // single-axis pushes both ways, diagonal with equal steps, extremes
        directed = '{
            mk(0, 0, 10, 10, 20, 20, 5, 5, 0, 0),
            mk(0, 0, 10, 10, 10, 0, 5, 5, 0, 0),
            mk(0, 0, 0, 10, 0, 0, 5, 5, 0, 0),
            mk(0, 0, 10, 10, 0, 0, 5, 0, 0, 0),
            mk(0, 0, 10, 10, 5, 5, 10, 10, 0, 0),
            mk(0, 0, 10, 10, 0, 0, 10, 10, 0, 0),
            mk(0, 0, 10, 4, 0, 2, 10, 4, 0, 0),
            mk(3, 0, 4, 10, 0, 2, 10, 20, 0, 0),
            mk(0, 0, 10, 10, 5, 3, 10, 10, 0, 256),
            mk(0, 0, 10, 10, 5, 3, 10, 10, 0, -256),
            mk(0, 0, 10, 10, 5, 3, 10, 10, 256, 0),
            mk(0, 0, 10, 10, 5, 3, 10, 10, -256, 0),
            mk(0, 0, 10, 10, 5, 5, 10, 10, 256, 256),
            mk(0, 0, 10, 10, 5, 5, 10, 10, -300, 77),
            mk(0, 0, 10, 10, 5, 5, 10, 10, 3, -32768),
            mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0),
            mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 32767, 1),
            mk(-32768, -32768, 32767, 32767, -1, -1, 32767, 32767, -32768, -32768),
            mk(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767, -1, 32767),
            mk(32767, 32767, 32767, 32767, 32766, 32766, 32767, 32767, 1, -1),
            mk(100, 100, 1, 1, 100, 100, 1, 1, 0, 0),
            mk(0, 0, 10, 10, -5, -5, 10, 10, 0, 0)
        };
        foreach (directed[i]) send_pair(directed[i]);
        drain();

        // Random phases: clean, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 18 : 0;
            recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 18 : 0;
            repeat (450) send_pair(rnd_pair());
            drain();
        end

        // Back pressure: receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (80) send_pair(rnd_pair());
        join
        drain();

        $display("covered %0d box pairs, %0d pushes checked, %0d with a hit",
                 sb.n_in, sb.n_out, sb.n_hits);
        $display("directed edge cases, four idle/stall mixes and a long output hold-off");
        if (err_cnt == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
